/* hw/rtl/tceb_pkg.sv */
// ----------------------------------------------------------------------------
// tceb_pkg
// Shared types and constants of the coincidence event builder.
// ----------------------------------------------------------------------------
package tceb_pkg;

	// fixed header bytes counted for every fragment
	localparam int unsigned FRAG_HDR_BYTES = 20;

	// field widths
	localparam int unsigned STAMP_W  = 64;
	localparam int unsigned BYTES_W  = 32;
	localparam int unsigned FRAGS_W  = 17;
	localparam int unsigned WINDOW_W = 31;
	localparam int unsigned LIMIT_W  = 16;
	localparam int unsigned SOURCE_W = 32;

	// stream widths
	localparam int unsigned IN_DATA_W  = 96;
	localparam int unsigned OUT_DATA_W = 152;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// divider step counter
	localparam int unsigned DIV_CNT_W = $clog2(STAMP_W);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW   = 3'd0,
		REG_DISABLE  = 3'd1,
		REG_POLICY   = 3'd2,
		REG_LIMIT    = 3'd3,
		REG_SOURCE   = 3'd4
	} reg_idx_t;

	// timestamp policy codes
	typedef enum logic [1:0] {
		POL_EARLIEST = 2'd0,
		POL_LATEST   = 2'd1,
		POL_AVERAGE  = 2'd2,
		POL_UNUSED   = 2'd3
	} policy_t;

	// operation codes
	localparam logic OP_FRAGMENT = 1'b0;
	localparam logic OP_FLUSH    = 1'b1;

	// configuration register set
	typedef struct packed {
		logic [WINDOW_W-1:0] window;
		logic                build_disable;
		logic [1:0]          policy;
		logic [LIMIT_W-1:0]  frag_limit;
		logic [SOURCE_W-1:0] source_tag;
	} cfg_t;

	// closed event handed from front to back
	typedef struct packed {
		logic [STAMP_W-1:0] stamp;   // chosen stamp, or stamp sum when averaging
		logic               avg;
		logic [BYTES_W-1:0] bytes;
		logic [FRAGS_W-1:0] frags;
	} evt_rec_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_HOLD
	} back_state_t;

endpackage

/* hw/rtl/timestamp_coincidence_event_builder_top.sv */
// ----------------------------------------------------------------------------
// timestamp_coincidence_event_builder_top
// Groups timestamped fragments into built events.
// ----------------------------------------------------------------------------
// Usage:
// - s_* stream carries one fragment or flush per beat; tuser is the
//   operation (0 fragment, 1 flush), tdata the stamp and payload size.
// - m_* stream carries one built event per beat.
// - cfg_* writes one register per beat; it is always ready and should be
//   used only while no event is pending in the block.
// Throughput: the front takes one beat a cycle while the event queue
//   (four entries) has room. A closed event goes straight to the output
//   register for the earliest and latest policies; the average policy runs a
//   bit-serial divider and takes no new event until the last one has been
//   divided and handed over, so that divider sets the event rate there.
// Path: the beat that closes an event pushes it into the queue; the back
//   loads it into the output register once free, via the divider if averaging.
// Reset: clears the open event, the queue and the output register, and
//   loads the register defaults (fragment limit 65535, others zero).
// Stall: with m_tready low the output register holds its beat; the queue
//   fills and then s_tready drops until events drain.
// ----------------------------------------------------------------------------
module timestamp_coincidence_event_builder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// fragment input
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tceb_pkg::IN_DATA_W-1:0]    s_tdata,  // [63:0] fragment_timestamp, [95:64] payload_bytes
	input  logic                              s_tuser,  // [0] operation
	// built events
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tceb_pkg::OUT_DATA_W-1:0]   m_tdata,  // [63:0] event_timestamp, [95:64] event_bytes,
	                                                    // [112:96] event_fragments, [144:113] event_source
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tceb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tceb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tceb_pkg::*;

	cfg_t               cfg_q;
	logic               push;
	logic               push_ready;
	evt_rec_t           push_rec;
	logic               pop;
	logic               head_valid;
	evt_rec_t           head_rec;
	logic [STAMP_W-1:0] ev_stamp;
	logic [BYTES_W-1:0] ev_bytes;
	logic [FRAGS_W-1:0] ev_frags;
	logic [SOURCE_W-1:0] ev_source;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window        <= '0;
			cfg_q.build_disable <= 1'b0;
			cfg_q.policy        <= POL_EARLIEST;
			cfg_q.frag_limit    <= '1;
			cfg_q.source_tag    <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_WINDOW:  cfg_q.window        <= cfg_data[WINDOW_W-1:0];
				REG_DISABLE: cfg_q.build_disable <= cfg_data[0];
				REG_POLICY:  cfg_q.policy        <= cfg_data[1:0];
				REG_LIMIT:   cfg_q.frag_limit    <= cfg_data[LIMIT_W-1:0];
				REG_SOURCE:  cfg_q.source_tag    <= cfg_data[SOURCE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: event accumulation
	tceb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_stamp   (s_tdata[63:0]),
		.in_payload (s_tdata[95:64]),
		.push       (push),
		.push_rec   (push_rec),
		.push_ready (push_ready)
	);

	// closed event queue
	tceb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.push_ready (push_ready),
		.pop        (pop),
		.head_rec   (head_rec),
		.head_valid (head_valid)
	);

	// back: stamp resolution and output
	tceb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_stamp  (ev_stamp),
		.out_bytes  (ev_bytes),
		.out_frags  (ev_frags),
		.out_source (ev_source)
	);

	// pack output beat
	assign m_tdata = {7'b0, ev_source, ev_frags, ev_bytes, ev_stamp};

endmodule

/* hw/rtl/tceb_front.sv */
// ----------------------------------------------------------------------------
// tceb_front
// Accepts fragment and flush beats, keeps the open event and pushes each
// closed event into the queue.
// ----------------------------------------------------------------------------
module tceb_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tceb_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_op,
	input  logic [tceb_pkg::STAMP_W-1:0] in_stamp,
	input  logic [tceb_pkg::BYTES_W-1:0] in_payload,
	output logic                         push,
	output tceb_pkg::evt_rec_t           push_rec,
	input  logic                         push_ready
);
	import tceb_pkg::*;

	logic               open_q;
	logic [STAMP_W-1:0] first_q;
	logic [STAMP_W-1:0] last_q;
	logic [STAMP_W-1:0] sum_q;
	logic [FRAGS_W-1:0] frags_q;
	logic [BYTES_W-1:0] bytes_q;

	logic               accept;
	logic [STAMP_W-1:0] d1;
	logic [STAMP_W-1:0] d2;
	logic               out_window;
	logic               close_frag;
	logic               restart;
	logic [BYTES_W-1:0] bytes_base;
	logic [BYTES_W+1:0] bytes_sum;
	logic [BYTES_W-1:0] bytes_next;

	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;

	// window test: the smaller distance is outside when both are
	assign d1         = in_stamp - first_q;
	assign d2         = first_q - in_stamp;
	assign out_window = (d1 > {{(STAMP_W-WINDOW_W){1'b0}}, cfg.window}) &&
	                    (d2 > {{(STAMP_W-WINDOW_W){1'b0}}, cfg.window});

	assign close_frag = open_q && (cfg.build_disable || out_window ||
	                    (frags_q > {1'b0, cfg.frag_limit}));
	assign restart    = !open_q || close_frag;

	// saturating byte count, header and payload in one add
	assign bytes_base = restart ? '0 : bytes_q;
	assign bytes_sum  = {2'b00, bytes_base} + (BYTES_W+2)'(FRAG_HDR_BYTES) +
	                    {2'b00, in_payload};
	assign bytes_next = (bytes_sum[BYTES_W+1:BYTES_W] != 2'b00) ? '1 :
	                    bytes_sum[BYTES_W-1:0];

	// push a closed event
	always_comb begin
		push = 1'b0;
		if (accept && open_q) begin
			if (in_op == OP_FLUSH) begin
				push = 1'b1;
			end else begin
				push = close_frag;
			end
		end
	end

	// pick the stamp operand by policy
	always_comb begin
		push_rec.avg   = 1'b0;
		push_rec.bytes = bytes_q;
		push_rec.frags = frags_q;
		case (policy_t'(cfg.policy))
			POL_LATEST: begin
				push_rec.stamp = last_q;
			end
			POL_AVERAGE: begin
				push_rec.stamp = sum_q;
				push_rec.avg   = 1'b1;
			end
			default: begin
				push_rec.stamp = first_q;
			end
		endcase
	end

	// open event control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (accept) begin
			open_q <= (in_op == OP_FRAGMENT);
		end
	end

	// open event contents
	always_ff @(posedge clk) begin
		if (accept && (in_op == OP_FRAGMENT)) begin
			last_q  <= in_stamp;
			bytes_q <= bytes_next;
			if (restart) begin
				first_q <= in_stamp;
				sum_q   <= in_stamp;
				frags_q <= FRAGS_W'(1);
			end else begin
				sum_q <= sum_q + in_stamp;
				if (frags_q != '1) begin
					frags_q <= frags_q + FRAGS_W'(1);
				end
			end
		end
	end

endmodule

/* hw/rtl/tceb_queue.sv */
// ----------------------------------------------------------------------------
// tceb_queue
// Short queue of closed events between the front and the back.
// ----------------------------------------------------------------------------
module tceb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tceb_pkg::evt_rec_t push_rec,
	output logic               push_ready,
	input  logic               pop,
	output tceb_pkg::evt_rec_t head_rec,
	output logic               head_valid
);
	import tceb_pkg::*;

	evt_rec_t           mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;
	assign head_rec   = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/tceb_back.sv */
// ----------------------------------------------------------------------------
// tceb_back
// Takes closed events from the queue, divides the stamp sum when
// averaging and drives the output register.
// ----------------------------------------------------------------------------
module tceb_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tceb_pkg::cfg_t                    cfg,
	input  logic                              head_valid,
	input  tceb_pkg::evt_rec_t                head_rec,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tceb_pkg::STAMP_W-1:0]      out_stamp,
	output logic [tceb_pkg::BYTES_W-1:0]      out_bytes,
	output logic [tceb_pkg::FRAGS_W-1:0]      out_frags,
	output logic [tceb_pkg::SOURCE_W-1:0]     out_source
);
	import tceb_pkg::*;

	back_state_t          state_q;
	back_state_t          state_next;

	logic                 out_valid_q;
	logic [STAMP_W-1:0]   out_stamp_q;
	logic [BYTES_W-1:0]   out_bytes_q;
	logic [FRAGS_W-1:0]   out_frags_q;
	logic [SOURCE_W-1:0]  out_source_q;

	// divider registers
	logic [STAMP_W-1:0]   quot_q;
	logic [FRAGS_W-1:0]   rem_q;
	logic [FRAGS_W-1:0]   divisor_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [BYTES_W-1:0]   hold_bytes_q;

	logic                 out_free;
	logic                 load_div;
	logic                 load_direct;
	logic                 load_quot;
	logic [FRAGS_W:0]     rem_shift;
	logic [FRAGS_W:0]     rem_diff;

	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			BK_IDLE: begin
				if (head_valid && head_rec.avg) begin
					state_next = BK_DIV;
				end
			end
			BK_DIV: begin
				if (cnt_q == '0) begin
					state_next = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (out_free) begin
					state_next = BK_IDLE;
				end
			end
			default: begin
				state_next = BK_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		load_div    = 1'b0;
		load_direct = 1'b0;
		load_quot   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				load_div    = head_valid && head_rec.avg;
				load_direct = head_valid && !head_rec.avg && out_free;
			end
			BK_HOLD: begin
				load_quot = out_free;
			end
			default: begin
			end
		endcase
	end

	assign pop = load_div || load_direct;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// restoring division, one quotient bit a cycle
	assign rem_shift = {rem_q, quot_q[STAMP_W-1]};
	assign rem_diff  = rem_shift - {1'b0, divisor_q};

	always_ff @(posedge clk) begin
		if (load_div) begin
			quot_q       <= head_rec.stamp;
			rem_q        <= '0;
			divisor_q    <= head_rec.frags;
			cnt_q        <= DIV_CNT_W'(STAMP_W - 1);
			hold_bytes_q <= head_rec.bytes;
		end else if (state_q == BK_DIV) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (!rem_diff[FRAGS_W]) begin
				rem_q  <= rem_diff[FRAGS_W-1:0];
				quot_q <= {quot_q[STAMP_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift[FRAGS_W-1:0];
				quot_q <= {quot_q[STAMP_W-2:0], 1'b0};
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_direct || load_quot) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_direct) begin
			out_stamp_q  <= head_rec.stamp;
			out_bytes_q  <= head_rec.bytes;
			out_frags_q  <= head_rec.frags;
			out_source_q <= cfg.source_tag;
		end else if (load_quot) begin
			out_stamp_q  <= quot_q;
			out_bytes_q  <= hold_bytes_q;
			out_frags_q  <= divisor_q;
			out_source_q <= cfg.source_tag;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_stamp  = out_stamp_q;
	assign out_bytes  = out_bytes_q;
	assign out_frags  = out_frags_q;
	assign out_source = out_source_q;

endmodule
